// ===== sv/assert_macros.svh =====
// assertion macros for the oven timer block
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define OTB_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define OTB_ASSERT_NXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/otb_pkg.sv =====
// shared widths, codes and types of the oven preheat timer block
// no dependencies
package otb_pkg;

	localparam int TEMP_FRAC_BITS = 4;

	localparam int TARGET_W  = 9;
	localparam int MIN_W     = 7;
	localparam int SEC_W     = 6;
	localparam int BAND_W    = 6;
	localparam int CFG_W     = 9;
	localparam int CFG_IDX_W = 2;
	localparam int OP_W      = 3;
	localparam int SAMPLE_W  = 14;
	localparam int PHASE_W   = 2;
	localparam int CYCLE_W   = 2;
	localparam int PROG_W    = 8;
	localparam int TIME_W    = 13;
	localparam int STEP_W    = 4;

	localparam int CMP_RAW_W = TARGET_W + TEMP_FRAC_BITS + 2;
	localparam int CMP_W     = (CMP_RAW_W > SAMPLE_W + 1) ? CMP_RAW_W : SAMPLE_W + 1;

	localparam int SECS_PER_MIN = 60;
	localparam logic [BAND_W-1:0] DEFAULT_BAND = BAND_W'(10);

	// divide by 60 as multiply by 8739 / 2^19, exact for all remaining times
	localparam int RECIP_W     = 14;
	localparam int RECIP_SHIFT = 19;
	localparam int PROD_W      = TIME_W + RECIP_W;
	localparam int QUOT_W      = PROD_W - RECIP_SHIFT;
	localparam logic [RECIP_W-1:0] RECIP_60 = RECIP_W'(8739);

	localparam logic [OP_W-1:0] OP_START = 3'd0;
	localparam logic [OP_W-1:0] OP_STOP  = 3'd1;
	localparam logic [OP_W-1:0] OP_POLL  = 3'd2;
	localparam logic [OP_W-1:0] OP_CTRL  = 3'd3;
	localparam logic [OP_W-1:0] OP_SEC   = 3'd4;

	localparam logic [CFG_IDX_W-1:0] CFG_TARGET  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MINUTES = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SECONDS = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_BAND    = 2'd3;

	localparam logic [PHASE_W-1:0] PH_IDLE    = 2'd0;
	localparam logic [PHASE_W-1:0] PH_PREHEAT = 2'd1;
	localparam logic [PHASE_W-1:0] PH_COOK    = 2'd2;

	localparam logic [CYCLE_W-1:0] CY_READ = 2'd0;
	localparam logic [CYCLE_W-1:0] CY_HOLD = 2'd1;
	localparam logic [CYCLE_W-1:0] CY_WAIT = 2'd2;

	typedef struct packed {
		logic              start;
		logic [STEP_W-1:0] steps;
		logic [TIME_W-1:0] num;
		logic [TIME_W-1:0] rem;
		logic [TIME_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic              done;
		logic [TIME_W-1:0] quot;
		logic [TIME_W-1:0] rem;
	} div_rsp_t;

endpackage

// ===== sv/otb_if.sv =====
// item channels of the oven preheat timer block: events in, status out
// depends on otb_pkg
interface otb_in_if;
	logic                          valid;
	logic                          ready;
	logic [otb_pkg::OP_W-1:0]      opcode;
	logic [otb_pkg::SAMPLE_W-1:0]  temp_sample;

	modport source (output valid, opcode, temp_sample, input ready);
	modport sink (input valid, opcode, temp_sample, output ready);
endinterface

interface otb_out_if;
	logic                         valid;
	logic                         ready;
	logic                         heater_on;
	logic [otb_pkg::PHASE_W-1:0]  phase;
	logic [otb_pkg::MIN_W-1:0]    minutes_left;
	logic [otb_pkg::SEC_W-1:0]    seconds_left;
	logic [otb_pkg::PROG_W-1:0]   progress;
	logic                         started;
	logic                         stopped;

	modport source (output valid, heater_on, phase, minutes_left, seconds_left, progress,
		started, stopped, input ready);
	modport sink (input valid, heater_on, phase, minutes_left, seconds_left, progress,
		started, stopped, output ready);
endinterface

// ===== sv/otb_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on otb_pkg
module otb_div (
	input  logic              clk,
	input  logic              arst_n,
	input  otb_pkg::div_req_t req,
	output otb_pkg::div_rsp_t rsp
);

	logic                          busy_q;
	logic                          done_q;
	logic [otb_pkg::STEP_W-1:0]    cnt_q;
	logic [otb_pkg::TIME_W-1:0]    num_q;
	logic [otb_pkg::TIME_W-1:0]    rem_q;
	logic [otb_pkg::TIME_W-1:0]    den_q;
	logic [otb_pkg::TIME_W:0]      part;
	logic [otb_pkg::TIME_W:0]      diff;
	logic                          fits;

	assign part = {rem_q, num_q[otb_pkg::TIME_W-1]};
	assign diff = part - {1'b0, den_q};
	assign fits = part >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= req.steps;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == otb_pkg::STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			num_q <= req.num;
			rem_q <= req.rem;
			den_q <= req.den;
		end else if (busy_q) begin
			num_q <= {num_q[otb_pkg::TIME_W-2:0], fits};
			rem_q <= fits ? diff[otb_pkg::TIME_W-1:0] : part[otb_pkg::TIME_W-1:0];
		end
	end

	assign rsp.done = done_q;
	assign rsp.quot = num_q;
	assign rsp.rem  = rem_q;

endmodule

// ===== sv/oven_preheat_bang_bang_timer_unit.sv =====
// top level of the oven preheat bang-bang timer: event decode, sequencer, status output
// depends on otb_pkg, otb_if, otb_div and assert_macros.svh
// while cooking with time left an item takes the minutes step and 8 divider steps for progress
// before the status load, else neither; output stalls delay the load; one item in work at a time
// reset: asynchronous, active low; idle, heater off, forced-off wait, elapsed zero,
// registers zero but preheat_band at 10
`include "assert_macros.svh"

module oven_preheat_bang_bang_timer_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	otb_in_if.sink                          in_ch,
	otb_out_if.source                       out_ch,
	input  logic                            cfg_we,
	input  logic [otb_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [otb_pkg::CFG_W-1:0]       cfg_data
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MIN  = 2'd1;
	localparam logic [1:0] S_PROG = 2'd2;
	localparam logic [1:0] S_LOAD = 2'd3;

	logic [1:0]                      seq_q;
	logic                            out_valid_q;

	logic [otb_pkg::TARGET_W-1:0]    target_temp_q;
	logic [otb_pkg::MIN_W-1:0]       cook_minutes_q;
	logic [otb_pkg::SEC_W-1:0]       cook_seconds_q;
	logic [otb_pkg::BAND_W-1:0]      preheat_band_q;

	logic [otb_pkg::PHASE_W-1:0]     phase_q;
	logic [otb_pkg::CYCLE_W-1:0]     cycle_q;
	logic                            heater_q;
	logic [otb_pkg::TIME_W-1:0]      elapsed_q;

	logic                            started_q;
	logic                            stopped_q;
	logic [otb_pkg::MIN_W-1:0]       mins_q;
	logic [otb_pkg::SEC_W-1:0]       secs_q;
	logic [otb_pkg::PROG_W-1:0]      prog_q;
	logic [otb_pkg::TIME_W-1:0]      delta_q;

	logic                            o_heater_q;
	logic [otb_pkg::PHASE_W-1:0]     o_phase_q;
	logic [otb_pkg::MIN_W-1:0]       o_mins_q;
	logic [otb_pkg::SEC_W-1:0]       o_secs_q;
	logic [otb_pkg::PROG_W-1:0]      o_prog_q;
	logic                            o_started_q;
	logic                            o_stopped_q;

	logic                            acc;
	logic                            load;
	logic signed [otb_pkg::CMP_W-1:0] sample_w;
	logic signed [otb_pkg::CMP_W-1:0] tgt_w;
	logic signed [otb_pkg::CMP_W-1:0] band_w;
	logic                            below;
	logic                            above;
	logic                            in_band;
	logic [otb_pkg::TIME_W-1:0]      total;
	logic [otb_pkg::TIME_W-1:0]      elapsed_inc;

	logic [otb_pkg::PHASE_W-1:0]     phase_n;
	logic [otb_pkg::CYCLE_W-1:0]     cycle_n;
	logic                            heater_n;
	logic [otb_pkg::TIME_W-1:0]      elapsed_n;
	logic                            started_n;
	logic                            stopped_n;
	logic                            time_left;
	logic [otb_pkg::TIME_W-1:0]      delta;

	logic [otb_pkg::PROD_W-1:0]      recip_prod;
	logic [otb_pkg::QUOT_W-1:0]      quot60;
	logic [otb_pkg::TIME_W-1:0]      rem60;

	otb_pkg::div_req_t               div_req;
	otb_pkg::div_rsp_t               div_rsp;

	otb_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	assign in_ch.ready = (seq_q == S_IDLE);
	assign acc  = in_ch.valid && in_ch.ready;
	assign load = (seq_q == S_LOAD) && (!out_valid_q || out_ch.ready);

	// temperatures compared in sample units
	assign sample_w = otb_pkg::CMP_W'(signed'(in_ch.temp_sample));
	assign tgt_w    = signed'(otb_pkg::CMP_W'(target_temp_q) << otb_pkg::TEMP_FRAC_BITS);
	assign band_w   = signed'(otb_pkg::CMP_W'(preheat_band_q) << otb_pkg::TEMP_FRAC_BITS);
	assign below    = sample_w < tgt_w;
	assign above    = sample_w > tgt_w;
	assign in_band  = (sample_w < tgt_w + band_w) && (sample_w > tgt_w - band_w);

	assign total = otb_pkg::TIME_W'(cook_minutes_q) * otb_pkg::TIME_W'(otb_pkg::SECS_PER_MIN)
		+ otb_pkg::TIME_W'(cook_seconds_q);
	assign elapsed_inc = (&elapsed_q) ? elapsed_q : elapsed_q + 1'b1;

	always_comb begin
		phase_n   = phase_q;
		cycle_n   = cycle_q;
		heater_n  = heater_q;
		elapsed_n = elapsed_q;
		started_n = 1'b0;
		stopped_n = 1'b0;
		case (in_ch.opcode)
			otb_pkg::OP_START: begin
				if (phase_q == otb_pkg::PH_IDLE) begin
					heater_n  = below;
					phase_n   = otb_pkg::PH_PREHEAT;
					cycle_n   = otb_pkg::CY_WAIT;
					elapsed_n = '0;
				end
			end
			otb_pkg::OP_STOP: begin
				if (phase_q != otb_pkg::PH_IDLE) begin
					heater_n  = 1'b0;
					phase_n   = otb_pkg::PH_IDLE;
					cycle_n   = otb_pkg::CY_WAIT;
					elapsed_n = '0;
					stopped_n = 1'b1;
				end
			end
			otb_pkg::OP_POLL: begin
				if (phase_q == otb_pkg::PH_PREHEAT && in_band) begin
					phase_n   = otb_pkg::PH_COOK;
					cycle_n   = otb_pkg::CY_WAIT;
					elapsed_n = '0;
					started_n = 1'b1;
				end
			end
			otb_pkg::OP_CTRL: begin
				if (phase_q == otb_pkg::PH_COOK) begin
					case (cycle_q)
						otb_pkg::CY_HOLD: cycle_n = otb_pkg::CY_WAIT;
						otb_pkg::CY_WAIT: begin
							cycle_n  = otb_pkg::CY_READ;
							heater_n = 1'b0;
						end
						default: begin
							if (below) begin
								heater_n = 1'b1;
								cycle_n  = otb_pkg::CY_HOLD;
							end else if (above) begin
								heater_n = 1'b0;
								cycle_n  = otb_pkg::CY_READ;
							end
						end
					endcase
				end
			end
			otb_pkg::OP_SEC: begin
				if (phase_q == otb_pkg::PH_COOK) begin
					elapsed_n = elapsed_inc;
					if (total <= elapsed_inc) begin
						heater_n  = 1'b0;
						phase_n   = otb_pkg::PH_IDLE;
						cycle_n   = otb_pkg::CY_WAIT;
						elapsed_n = '0;
						stopped_n = 1'b1;
					end
				end
			end
			default: ;
		endcase
	end

	assign time_left = (phase_n == otb_pkg::PH_COOK) && (total > elapsed_n);
	assign delta     = total - elapsed_n;

	// minutes and seconds by reciprocal multiply, progress by the divider
	assign recip_prod = otb_pkg::PROD_W'(delta_q) * otb_pkg::PROD_W'(otb_pkg::RECIP_60);
	assign quot60     = recip_prod[otb_pkg::PROD_W-1:otb_pkg::RECIP_SHIFT];
	assign rem60      = delta_q
		- otb_pkg::TIME_W'(quot60) * otb_pkg::TIME_W'(otb_pkg::SECS_PER_MIN);

	always_comb begin
		div_req.start = (seq_q == S_MIN);
		div_req.steps = otb_pkg::STEP_W'(otb_pkg::PROG_W);
		div_req.num   = '0;
		div_req.rem   = elapsed_q;
		div_req.den   = total;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seq_q          <= S_IDLE;
			out_valid_q    <= 1'b0;
			target_temp_q  <= '0;
			cook_minutes_q <= '0;
			cook_seconds_q <= '0;
			preheat_band_q <= otb_pkg::DEFAULT_BAND;
			phase_q        <= otb_pkg::PH_IDLE;
			cycle_q        <= otb_pkg::CY_WAIT;
			heater_q       <= 1'b0;
			elapsed_q      <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					otb_pkg::CFG_TARGET:  target_temp_q  <= cfg_data[otb_pkg::TARGET_W-1:0];
					otb_pkg::CFG_MINUTES: cook_minutes_q <= cfg_data[otb_pkg::MIN_W-1:0];
					otb_pkg::CFG_SECONDS: cook_seconds_q <= cfg_data[otb_pkg::SEC_W-1:0];
					otb_pkg::CFG_BAND:    preheat_band_q <= cfg_data[otb_pkg::BAND_W-1:0];
					default: ;
				endcase
			end
			if (load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (seq_q)
				S_IDLE: begin
					if (acc) begin
						phase_q   <= phase_n;
						cycle_q   <= cycle_n;
						heater_q  <= heater_n;
						elapsed_q <= elapsed_n;
						seq_q     <= time_left ? S_MIN : S_LOAD;
					end
				end
				S_MIN: begin
					seq_q <= S_PROG;
				end
				S_PROG: begin
					if (div_rsp.done) begin
						seq_q <= S_LOAD;
					end
				end
				default: begin
					if (load) begin
						seq_q <= S_IDLE;
					end
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (seq_q == S_IDLE && acc) begin
			started_q <= started_n;
			stopped_q <= stopped_n;
			mins_q    <= '0;
			secs_q    <= '0;
			prog_q    <= (phase_n == otb_pkg::PH_COOK) ? '1 : '0;
			delta_q   <= delta;
		end
		if (seq_q == S_MIN) begin
			mins_q <= quot60[otb_pkg::MIN_W] ? '1 : quot60[otb_pkg::MIN_W-1:0];
			secs_q <= rem60[otb_pkg::SEC_W-1:0];
		end
		if (seq_q == S_PROG && div_rsp.done) begin
			prog_q <= div_rsp.quot[otb_pkg::PROG_W-1:0];
		end
		if (load) begin
			o_heater_q  <= heater_q;
			o_phase_q   <= phase_q;
			o_mins_q    <= mins_q;
			o_secs_q    <= secs_q;
			o_prog_q    <= prog_q;
			o_started_q <= started_q;
			o_stopped_q <= stopped_q;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.heater_on    = o_heater_q;
	assign out_ch.phase        = o_phase_q;
	assign out_ch.minutes_left = o_mins_q;
	assign out_ch.seconds_left = o_secs_q;
	assign out_ch.progress     = o_prog_q;
	assign out_ch.started      = o_started_q;
	assign out_ch.stopped      = o_stopped_q;

	`OTB_ASSERT_IMP(a_idle_heater_off, clk, arst_n, phase_q == otb_pkg::PH_IDLE, !heater_q, "heater on while idle")
	`OTB_ASSERT_IMP(a_idle_elapsed_zero, clk, arst_n, phase_q == otb_pkg::PH_IDLE, elapsed_q == '0, "elapsed time kept while idle")
	`OTB_ASSERT_IMP(a_div_done_in_pass, clk, arst_n, div_rsp.done, seq_q == S_MIN || seq_q == S_PROG, "divider finished outside a divide pass")
	`OTB_ASSERT_NXT(a_busy_after_accept, clk, arst_n, acc, !in_ch.ready, "item accepted while previous item in work")

endmodule

// ===== tb/otb_status_checker.sv =====
`timescale 1ns / 100ps
// checker of the oven preheat timer: follows register writes and event items, predicts each
// status item and compares it field by field; depends on otb_pkg and otb_if
module otb_status_checker
	import otb_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	otb_in_if                    in_ch,
	otb_out_if                   out_ch,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data,
	output int                   fails,
	output int                   pending,
	output int                   checked
);

	typedef struct packed {
		logic               heater_on;
		logic [PHASE_W-1:0] phase;
		logic [MIN_W-1:0]   minutes_left;
		logic [SEC_W-1:0]   seconds_left;
		logic [PROG_W-1:0]  progress;
		logic               started;
		logic               stopped;
	} status_t;

	logic [TARGET_W-1:0] tgt_deg;
	logic [MIN_W-1:0]    cfg_min;
	logic [SEC_W-1:0]    cfg_sec;
	logic [BAND_W-1:0]   band_deg;

	logic [PHASE_W-1:0]  ph;
	logic [CYCLE_W-1:0]  cyc;
	logic                heat;
	logic [TIME_W-1:0]   elapsed;

	status_t status_q[$];
	int      errs;
	int      n_checked;

	function automatic void to_idle();
		heat = 1'b0;
		ph = PH_IDLE;
		cyc = CY_WAIT;
		elapsed = '0;
	endfunction

	function automatic status_t oven_next(logic [OP_W-1:0] op, logic signed [SAMPLE_W-1:0] smp);
		int s;
		int t;
		int b;
		int total;
		int delta;
		int mins;
		status_t r;
		s = smp;
		t = int'(tgt_deg) << TEMP_FRAC_BITS;
		b = int'(band_deg) << TEMP_FRAC_BITS;
		r = '0;
		case (op)
			OP_START: if (ph == PH_IDLE) begin
				heat = (s < t);
				ph = PH_PREHEAT;
				cyc = CY_WAIT;
				elapsed = '0;
			end
			OP_STOP: if (ph != PH_IDLE) begin
				to_idle();
				r.stopped = 1'b1;
			end
			OP_POLL: if (ph == PH_PREHEAT && s < t + b && s > t - b) begin
				ph = PH_COOK;
				cyc = CY_WAIT;
				elapsed = '0;
				r.started = 1'b1;
			end
			OP_CTRL: if (ph == PH_COOK) begin
				case (cyc)
					CY_HOLD: cyc = CY_WAIT;
					CY_WAIT: begin
						cyc = CY_READ;
						heat = 1'b0;
					end
					default: begin
						if (s < t) begin
							heat = 1'b1;
							cyc = CY_HOLD;
						end else if (s > t) begin
							heat = 1'b0;
							cyc = CY_READ;
						end
					end
				endcase
			end
			OP_SEC: if (ph == PH_COOK) begin
				if (elapsed != {TIME_W{1'b1}})
					elapsed = elapsed + 1'b1;
				if (int'(cfg_min) * SECS_PER_MIN + int'(cfg_sec) <= int'(elapsed)) begin
					to_idle();
					r.stopped = 1'b1;
				end
			end
			default: ;
		endcase
		if (ph == PH_COOK) begin
			total = int'(cfg_min) * SECS_PER_MIN + int'(cfg_sec);
			if (total > int'(elapsed)) begin
				delta = total - int'(elapsed);
				mins = delta / SECS_PER_MIN;
				if (mins > 127)
					mins = 127;
				r.minutes_left = MIN_W'(mins);
				r.seconds_left = SEC_W'(delta % SECS_PER_MIN);
				r.progress = PROG_W'((int'(elapsed) * 256) / total);
			end else begin
				r.progress = 8'd255;
			end
		end
		r.heater_on = heat;
		r.phase = ph;
		return r;
	endfunction

	function automatic void check_field(string name, int want, int got);
		if (want != got) begin
			$error("%s expected %0d got %0d", name, want, got);
			errs++;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		status_t want;
		if (!arst_n) begin
			tgt_deg = '0;
			cfg_min = '0;
			cfg_sec = '0;
			band_deg = DEFAULT_BAND;
			to_idle();
			status_q.delete();
			errs = 0;
			n_checked = 0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (status_q.size() == 0) begin
					$error("status item with no event item waiting");
					errs++;
				end else begin
					want = status_q.pop_front();
					check_field("heater_on", want.heater_on, out_ch.heater_on);
					check_field("phase", want.phase, out_ch.phase);
					check_field("minutes_left", want.minutes_left, out_ch.minutes_left);
					check_field("seconds_left", want.seconds_left, out_ch.seconds_left);
					check_field("progress", want.progress, out_ch.progress);
					check_field("started", want.started, out_ch.started);
					check_field("stopped", want.stopped, out_ch.stopped);
					n_checked++;
				end
			end
			if (cfg_we) begin
				case (cfg_index)
					CFG_TARGET:  tgt_deg = cfg_data[TARGET_W-1:0];
					CFG_MINUTES: cfg_min = cfg_data[MIN_W-1:0];
					CFG_SECONDS: cfg_sec = cfg_data[SEC_W-1:0];
					CFG_BAND:    band_deg = cfg_data[BAND_W-1:0];
					default: ;
				endcase
			end
			if (in_ch.valid && in_ch.ready)
				status_q.push_back(oven_next(in_ch.opcode, in_ch.temp_sample));
		end
		fails <= errs;
		pending <= status_q.size();
		checked <= n_checked;
	end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// top of the oven preheat timer testbench: clock, reset, register writes and event stimulus
// depends on otb_pkg, otb_if, otb_status_checker and the oven_preheat_bang_bang_timer_unit
module tb_top;
	import otb_pkg::*;

	localparam int LIMIT = 800000;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_W-1:0]     cfg_data;

	int  fails;
	int  pending;
	int  checked;
	int  items;
	int  n_settings;
	int  cur_tgt;
	int  cur_min;
	int  cur_sec;
	int  cur_band;
	bit  steady;

	otb_in_if  in_ch();
	otb_out_if out_ch();

	oven_preheat_bang_bang_timer_unit uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	otb_status_checker chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending),
		.checked   (checked)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (LIMIT) @(posedge clk);
		$display("== FAIL ==");
		$finish;
	end

	// mostly short gaps, a few long ones, none in steady stretches
	function automatic int idle_len();
		int r;
		if (steady)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(10, 40);
	endfunction

	initial begin
		int n;
		out_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			n = steady ? 1 : $urandom_range(1, 12);
			out_ch.ready <= 1'b1;
			repeat (n) @(posedge clk);
			n = idle_len();
			if (n > 0) begin
				out_ch.ready <= 1'b0;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_item(input logic [OP_W-1:0] op, input logic [SAMPLE_W-1:0] smp);
		int gap;
		gap = idle_len();
		if (gap > 0) begin
			in_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.opcode <= op;
		in_ch.temp_sample <= smp;
		do @(posedge clk); while (!in_ch.ready);
		items++;
	endtask

	task automatic drain();
		in_ch.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (32) @(posedge clk);
	endtask

	task automatic cfg_put(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_W'(val);
		@(posedge clk);
	endtask

	task automatic write_config(input int t, input int m, input int s, input int b);
		cur_tgt = t;
		cur_min = m;
		cur_sec = s;
		cur_band = b;
		cfg_put(CFG_TARGET, t);
		cfg_put(CFG_MINUTES, m);
		cfg_put(CFG_SECONDS, s);
		cfg_put(CFG_BAND, b);
		cfg_we <= 1'b0;
		n_settings++;
	endtask

	function automatic logic [SAMPLE_W-1:0] around_target(int spread);
		int v;
		v = cur_tgt * 16 + int'($urandom_range(0, 2 * spread)) - spread;
		return v[SAMPLE_W-1:0];
	endfunction

	task automatic maybe_noise();
		if ($urandom_range(0, 11) == 0)
			send_item(OP_W'($urandom_range(0, 7)), SAMPLE_W'($urandom));
	endtask

	// one cooking run: start, a few polls, then control items and ticks until timeout or stop
	task automatic cook_run();
		int total;
		int nsec;
		maybe_noise();
		send_item(OP_START, $urandom_range(0, 1) ? around_target(cur_band * 16 + 40)
			: SAMPLE_W'($urandom));
		repeat ($urandom_range(0, 3)) begin
			maybe_noise();
			send_item(OP_POLL, $urandom_range(0, 1) ? around_target(cur_band * 16 + 40)
				: SAMPLE_W'($urandom));
		end
		if (cur_band == 0 || $urandom_range(0, 9) == 0) begin
			send_item(OP_STOP, SAMPLE_W'($urandom));
			return;
		end
		send_item(OP_POLL, around_target(cur_band * 16 - 1));
		total = cur_min * 60 + cur_sec;
		nsec = (total == 0) ? 1 : (total > 24 ? 24 : total);
		repeat (nsec) begin
			repeat ($urandom_range(0, 3))
				send_item(OP_CTRL, around_target($urandom_range(0, 1) ? 1 : 40));
			maybe_noise();
			if ($urandom_range(0, 39) == 0) begin
				send_item(OP_STOP, SAMPLE_W'($urandom));
				return;
			end
			send_item(OP_SEC, SAMPLE_W'($urandom));
		end
		if (total > 24)
			send_item(OP_STOP, SAMPLE_W'($urandom));
	endtask

	initial begin
		arst_n = 1'b0;
		in_ch.valid <= 1'b0;
		in_ch.opcode <= OP_START;
		in_ch.temp_sample <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_TARGET;
		cfg_data <= '0;
		items = 0;
		n_settings = 0;
		cur_tgt = 0;
		cur_min = 0;
		cur_sec = 0;
		cur_band = 10;
		steady = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ignored events while idle, unused opcodes, stop during preheat
		send_item(OP_STOP, 14'd0);
		send_item(OP_POLL, 14'd0);
		send_item(OP_CTRL, 14'd0);
		send_item(OP_SEC, 14'd0);
		send_item(3'd5, 14'h1fff);
		send_item(3'd6, 14'h3c00);
		send_item(3'd7, 14'h2000);
		send_item(OP_START, 14'h2000);
		send_item(OP_START, 14'd0);
		send_item(OP_STOP, 14'd0);
		drain();

		// band edges, read cycle with equal sample, timeout
		write_config(100, 0, 2, 10);
		send_item(OP_START, 14'h1fff);
		send_item(OP_POLL, 14'd1760);
		send_item(OP_POLL, 14'd1440);
		send_item(OP_POLL, 14'd1759);
		send_item(OP_CTRL, 14'd0);
		send_item(OP_CTRL, 14'd1600);
		send_item(OP_CTRL, 14'd1599);
		send_item(OP_CTRL, 14'd0);
		send_item(OP_CTRL, 14'd0);
		send_item(OP_CTRL, 14'd1601);
		send_item(OP_SEC, 14'd0);
		send_item(OP_SEC, 14'd0);
		send_item(OP_START, 14'd0);
		send_item(OP_POLL, 14'd1441);
		send_item(OP_SEC, 14'd0);
		drain();

		// cooking time shortened below elapsed time
		write_config(100, 0, 0, 10);
		send_item(OP_CTRL, 14'd0);
		send_item(OP_SEC, 14'd0);
		drain();

		while (items < 750) begin
			case (n_settings)
				3: write_config(0, 0, 0, 10);
				4: write_config(511, 0, 3, 63);
				5: write_config(100, 0, 5, 0);
				6: write_config(511, 127, 63, 1);
				7: write_config(0, 99, 59, 63);
				default: write_config($urandom_range(0, 511),
					$urandom_range(0, 3) == 0 ? $urandom_range(0, 99) : 0,
					$urandom_range(0, 20), $urandom_range(0, 63));
			endcase
			steady = (n_settings % 4 == 3);
			repeat (4) begin
				if (items < 750)
					cook_run();
			end
			drain();
		end
		steady = 1'b0;

		drain();
		$display("covered %0d event items over %0d register settings, %0d status items compared",
			items, n_settings, checked);
		if (fails == 0 && pending == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
